// File: sv/top_n_largest_distinct_tracker_assert.svh
// Assertion macros used by the tracker back end (tndt_back).
`ifndef TOP_N_LARGEST_DISTINCT_TRACKER_ASSERT_SVH
`define TOP_N_LARGEST_DISTINCT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TNDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TNDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

// File: sv/tndt_pkg.sv
`timescale 1ns / 1ps

package tndt_pkg;

  localparam int VALUE_W       = 64;
  localparam int KEEP_W        = 7;
  localparam int TOP_COUNT_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd16;

  // Item kinds on the input channel.
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic                      is_read;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  // Effective keep count: zero counts as one, and values above the capacity clamp.
  function automatic logic [KEEP_W-1:0] eff_keep(input logic [KEEP_W-1:0] kc,
                                                 input logic [KEEP_W-1:0] cap);
    logic [KEEP_W-1:0] k;
    k = kc;
    if (kc == '0) begin
      k = 7'd1;
    end else if (kc > cap) begin
      k = cap;
    end
    return k;
  endfunction

endpackage

// File: sv/top_n_largest_distinct_tracker.sv
`timescale 1ns / 1ps

// Streaming top-k tracker. The block holds, largest first, the distinct signed
// 64-bit values it has been offered, at most k of them, where k is the keep_count
// register clamped to 1..TOP_COUNT (zero counts as one). An offer (kind 0) that
// equals a held entry is ignored; otherwise it is inserted in order while fewer
// than k are held, and once k are held it displaces the smallest entry only if it
// is larger. A readout (kind 1) returns the held entries highest first with
// present set and last_of_run on the final one; an empty list returns a single
// item with held_value 0, present 0 and last_of_run 1. Writing a smaller
// keep_count drops the smallest entries. Items enter through a one-item input
// register and a two-entry queue, so the input side keeps accepting up to three
// items while the back end is busy with a readout or the output stalls. In the
// back end an offer is handled by the compare-and-shift over all TOP_COUNT entry
// cells, so offers run at one item per clock while no readout is in progress.
// A readout of n entries occupies the back end until its last result (the single
// item for an empty list) is loaded into the output stage, one result per cycle
// through a registered output stage while the consumer holds out_ready high.
// Configuration is always ready and must only be written while the block is idle.

module top_n_largest_distinct_tracker #(
  parameter int TOP_COUNT = tndt_pkg::TOP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic signed [tndt_pkg::VALUE_W-1:0] in_sample_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tndt_pkg::KEEP_W-1:0]         cfg_keep_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tndt_pkg::VALUE_W-1:0] out_held_value,
  output logic                                out_present,
  output logic                                out_last_of_run
);

  // Front end to queue.
  logic            f_valid;
  logic            f_ready;
  tndt_pkg::item_t f_item;

  // Queue to back end.
  logic            q_valid;
  logic            q_ready;
  tndt_pkg::item_t q_item;

  // The front end registers each item and tags it as an offer or a readout.
  tndt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_sample_value (in_sample_value),
    .f_valid         (f_valid),
    .f_ready         (f_ready),
    .f_item          (f_item)
  );

  // The queue decouples the front end from a back end busy with a readout.
  tndt_queue #(
    .DEPTH (tndt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // The back end holds the sorted list, the fill count and the keep register.
  tndt_back #(
    .TOP_COUNT (TOP_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_keep_count  (cfg_keep_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_held_value  (out_held_value),
    .out_present     (out_present),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: sv/tndt_front.sv
`timescale 1ns / 1ps

module tndt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic signed [tndt_pkg::VALUE_W-1:0] in_sample_value,
  output logic                                f_valid,
  input  logic                                f_ready,
  output tndt_pkg::item_t                     f_item
);

  logic            hold_valid_r;
  logic            hold_valid_nxt;
  tndt_pkg::item_t hold_r;
  logic            accept;

  assign in_ready = !hold_valid_r || f_ready;
  assign accept   = in_valid && in_ready;
  assign f_valid  = hold_valid_r;
  assign f_item   = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (f_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // The value is dropped to zero on a readout so the back end sees a clean item.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.is_read <= (in_kind == tndt_pkg::KIND_READ);
      hold_r.value   <= (in_kind == tndt_pkg::KIND_READ) ? '0 : in_sample_value;
    end
  end

endmodule

// File: sv/tndt_queue.sv
`timescale 1ns / 1ps

module tndt_queue #(
  parameter int DEPTH = tndt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  tndt_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tndt_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tndt_pkg::item_t    slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               push;
  logic               pop;

  assign push_ready = (count_r < CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/tndt_back.sv
`timescale 1ns / 1ps
`include "top_n_largest_distinct_tracker_assert.svh"

module tndt_back #(
  parameter int TOP_COUNT = tndt_pkg::TOP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  tndt_pkg::item_t                     q_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tndt_pkg::KEEP_W-1:0]         cfg_keep_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tndt_pkg::VALUE_W-1:0] out_held_value,
  output logic                                out_present,
  output logic                                out_last_of_run
);

  localparam int CNT_W = $clog2(TOP_COUNT + 1);
  localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam logic [tndt_pkg::KEEP_W-1:0] CAP = tndt_pkg::KEEP_W'(TOP_COUNT);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                                state_r;
  state_t                                state_nxt;
  logic signed [tndt_pkg::VALUE_W-1:0]   entry_r [TOP_COUNT];
  logic [CNT_W-1:0]                      filled_r;
  logic [CNT_W-1:0]                      filled_nxt;
  logic [tndt_pkg::KEEP_W-1:0]           keep_r;
  logic [tndt_pkg::KEEP_W-1:0]           keep_nxt;
  logic [IDX_W-1:0]                      rd_idx_r;
  logic [IDX_W-1:0]                      rd_idx_nxt;
  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  logic signed [tndt_pkg::VALUE_W-1:0]   out_value_r;
  logic signed [tndt_pkg::VALUE_W-1:0]   out_value_nxt;
  logic                                  out_present_r;
  logic                                  out_present_nxt;
  logic                                  out_last_r;
  logic                                  out_last_nxt;

  logic [CNT_W-1:0]                      k_eff;
  logic [CNT_W-1:0]                      k_cfg;
  logic [TOP_COUNT-1:0]                  vld;
  logic [TOP_COUNT-1:0]                  eq;
  logic [TOP_COUNT-1:0]                  kept;
  logic [TOP_COUNT-1:0]                  beat;
  logic [TOP_COUNT-1:0]                  wr;
  logic signed [tndt_pkg::VALUE_W-1:0]   shift_val [TOP_COUNT];
  logic                                  dup;
  logic                                  ins;
  logic                                  ins_go;
  logic                                  full;
  logic                                  slot_free;
  logic                                  rd_last;

  assign k_eff     = CNT_W'(tndt_pkg::eff_keep(keep_r, CAP));
  assign k_cfg     = CNT_W'(tndt_pkg::eff_keep(cfg_keep_count, CAP));
  assign cfg_ready = 1'b1;

  // Compare-and-shift cells: every cell compares its entry against the offered value.
  genvar g;
  generate
    for (g = 0; g < TOP_COUNT; g++) begin : g_cell
      assign vld[g]  = (CNT_W'(g) < filled_r);
      assign eq[g]   = vld[g] && (entry_r[g] == q_item.value);
      assign kept[g] = vld[g] && (entry_r[g] > q_item.value);
      assign beat[g] = (CNT_W'(g) < k_eff) && !kept[g];
      assign wr[g]   = ins_go && (CNT_W'(g) <= filled_r) && (CNT_W'(g) < k_eff) && !kept[g];
      if (g == 0) begin : g_head
        assign shift_val[g] = q_item.value;
      end else begin : g_body
        assign shift_val[g] = kept[g-1] ? q_item.value : entry_r[g-1];
      end
      always_ff @(posedge clk) begin
        if (wr[g]) begin
          entry_r[g] <= shift_val[g];
        end
      end
    end
  endgenerate

  // The list is sorted, so a free slot below k exists exactly when the value
  // either fits into a list that is not full or beats its smallest entry.
  assign dup     = |eq;
  assign ins     = !dup && (|beat);
  assign full    = (filled_r >= k_eff);
  assign ins_go  = (state_r == ST_IDLE) && q_valid && !q_item.is_read && ins;
  assign q_ready = (state_r == ST_IDLE);

  assign slot_free = !out_valid_r || out_ready;
  assign rd_last   = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == filled_r);

  always_comb begin
    state_nxt       = state_r;
    filled_nxt      = filled_r;
    keep_nxt        = keep_r;
    rd_idx_nxt      = rd_idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_value_nxt   = out_value_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.is_read) begin
            state_nxt  = ST_READ;
            rd_idx_nxt = '0;
          end else if (ins) begin
            filled_nxt = full ? filled_r : filled_r + CNT_W'(1);
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (filled_r == '0) begin
            out_value_nxt   = '0;
            out_present_nxt = 1'b0;
            out_last_nxt    = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            out_value_nxt   = entry_r[rd_idx_r];
            out_present_nxt = 1'b1;
            out_last_nxt    = rd_last;
            if (rd_last) begin
              state_nxt = ST_IDLE;
            end else begin
              rd_idx_nxt = rd_idx_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // User must send configuration only while idle (unenforced); shrinking k drops the smallest entries.
    if (cfg_valid) begin
      keep_nxt = cfg_keep_count;
      if (filled_r > k_cfg) begin
        filled_nxt = k_cfg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      filled_r      <= '0;
      keep_r        <= tndt_pkg::KEEP_RESET;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
      out_value_r   <= '0;
      out_present_r <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      filled_r      <= filled_nxt;
      keep_r        <= keep_nxt;
      rd_idx_r      <= rd_idx_nxt;
      out_valid_r   <= out_valid_nxt;
      out_value_r   <= out_value_nxt;
      out_present_r <= out_present_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_held_value  = out_value_r;
  assign out_present     = out_present_r;
  assign out_last_of_run = out_last_r;

  `TNDT_ASSERT_IMP(a_fill_within_k, clk, rst_n, 1'b1, filled_r <= k_eff)
  `TNDT_ASSERT_IMP(a_read_index_held, clk, rst_n, (state_r == ST_READ) && (filled_r != '0), CNT_W'(rd_idx_r) < filled_r)
  `TNDT_ASSERT_NXT(a_read_freezes_list, clk, rst_n, (state_r == ST_READ) && !cfg_valid, $stable(filled_r))
  generate
    for (g = 1; g < TOP_COUNT; g++) begin : g_order_chk
      `TNDT_ASSERT_IMP(a_strict_order, clk, rst_n, CNT_W'(g) < filled_r, entry_r[g-1] > entry_r[g])
    end
  endgenerate

endmodule
